>>> hw/rtl/gic_pkg.sv
package gic_pkg;

  // Deadzone radii and the offset margin (offset = radius - margin).
  localparam int unsigned DZ_NORMAL = 8;
  localparam int unsigned DZ_ALT    = 12;
  localparam int unsigned DZ_MARGIN = 2;

  // A squared length above this (64 * 64) gets the vector limited.
  localparam int unsigned MAG_LIMIT_SQ = 4096;
  // Limited magnitude, 64.0 in Q8.
  localparam int unsigned MAG_FULL = 16384;

  // Widths of the shared arithmetic units.
  localparam int unsigned SQ_W   = 14;  // one deadzoned axis squared
  localparam int unsigned SUM_W  = 15;  // x*x + y*y
  localparam int unsigned RAD_W  = 31;  // square root operand
  localparam int unsigned ROOT_W = 16;  // square root result
  localparam int unsigned REM_W  = 17;  // square root remainder
  localparam int unsigned QUO_W  = 31;  // quotient of the axis scaling divide
  localparam int unsigned MAG_W  = 15;

  // Configuration register indexes.
  localparam logic REG_ALT_MODE   = 1'b0;
  localparam logic REG_COMBO_MASK = 1'b1;

  // One classified frame, handed from the front end to the back end.
  typedef struct packed {
    logic [15:0]        held;
    logic [15:0]        pressed;
    logic [15:0]        released;
    logic               combo;
    logic               zero_stick;
    logic signed [7:0]  x;
    logic signed [7:0]  y;
  } gic_job_t;

  // Deadzone with offset on one raw axis sample.
  function automatic logic signed [7:0] dead_axis(input logic signed [7:0] v,
                                                  input logic alt);
    logic signed [8:0] v9;
    logic signed [8:0] d;
    logic signed [8:0] off;
    v9  = {v[7], v};
    d   = alt ? $signed(9'(DZ_ALT)) : $signed(9'(DZ_NORMAL));
    off = d - $signed(9'(DZ_MARGIN));
    if (v9 <= -d) begin
      dead_axis = 8'(v9 + off);
    end else if (v9 >= d) begin
      dead_axis = 8'(v9 - off);
    end else begin
      dead_axis = '0;
    end
  endfunction

endpackage

>>> hw/rtl/gic_if.sv
// Frame request channel.
interface gic_in_if;
  logic              valid;
  logic              ready;
  logic              connected;
  logic              lock_request;
  logic signed [7:0] raw_x;
  logic signed [7:0] raw_y;
  logic [15:0]       buttons;

  modport source(output valid, connected, lock_request, raw_x, raw_y, buttons,
                 input ready);
  modport sink(input valid, connected, lock_request, raw_x, raw_y, buttons,
               output ready);
endinterface

// Conditioned result channel.
interface gic_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        held_buttons;
  logic [15:0]        pressed_buttons;
  logic [15:0]        released_buttons;
  logic               combo_hit;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  logic [14:0]        stick_mag;

  modport source(output valid, held_buttons, pressed_buttons, released_buttons,
                 combo_hit, stick_x, stick_y, stick_mag, input ready);
  modport sink(input valid, held_buttons, pressed_buttons, released_buttons,
               combo_hit, stick_x, stick_y, stick_mag, output ready);
endinterface

>>> hw/rtl/gic_front.sv
module gic_front import gic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  gic_in_if.sink      pad,
  input  logic        alt_mode,
  input  logic [15:0] combo_mask,
  output logic        push_valid,
  input  logic        push_ready,
  output gic_job_t    push_job
);

  logic [15:0] held_mask;
  logic [15:0] locked_mask;
  logic [15:0] lock_new;
  logic [15:0] held;
  logic [15:0] pressed;
  logic [15:0] released;
  logic signed [7:0] dx;
  logic signed [7:0] dy;
  logic accept;

  assign pad.ready  = push_ready;
  assign push_valid = pad.valid;
  assign accept     = pad.valid && push_ready;

  always_comb begin
    // A lock request takes the current buttons; a lock only lasts while the
    // button stays down.
    lock_new = (pad.lock_request ? pad.buttons : locked_mask) & pad.buttons;
    held     = pad.buttons & ~lock_new;
    pressed  = held & ~held_mask;
    released = held_mask & ~held;
    dx       = dead_axis(pad.raw_x, alt_mode);
    dy       = dead_axis(pad.raw_y, alt_mode);

    push_job = '0;
    if (pad.connected) begin
      push_job.held       = held;
      push_job.pressed    = pressed;
      push_job.released   = released;
      push_job.combo      = ((held & combo_mask) == combo_mask) &&
                            ((pressed & combo_mask) != '0);
      push_job.x          = dx;
      push_job.y          = dy;
      push_job.zero_stick = (dx == '0) && (dy == '0);
    end else begin
      push_job.zero_stick = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mask   <= '0;
      locked_mask <= '0;
    end else if (accept) begin
      if (pad.connected) begin
        held_mask   <= held;
        locked_mask <= lock_new;
      end else begin
        held_mask <= '0;
      end
    end
  end

endmodule

>>> hw/rtl/gic_queue.sv
module gic_queue import gic_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  gic_job_t push_job,
  output logic     pop_valid,
  input  logic     pop,
  output gic_job_t pop_job
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gic_job_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/gic_div.sv
module gic_div import gic_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SQ_W-1:0]  num_sq,
  input  logic [SUM_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quot
);

  // Restoring divide of num_sq * 2^30 by den, one quotient bit per cycle.
  logic             busy;
  logic [4:0]       cnt;
  logic [SUM_W:0]   rem;
  logic [SUM_W:0]   shifted;
  logic             ge;
  logic             init_ge;

  assign shifted = {rem[SUM_W-1:0], 1'b0};
  assign ge      = shifted >= {1'b0, den};
  assign init_ge = {1'b0, num_sq} >= den;

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= init_ge ? (SUM_W+1)'({1'b0, num_sq}) - (SUM_W+1)'(den)
                      : (SUM_W+1)'(num_sq);
      quot <= QUO_W'(init_ge);
    end else if (busy) begin
      rem  <= ge ? shifted - {1'b0, den} : shifted;
      quot <= {quot[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'(QUO_W - 2)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/gic_sqrt.sv
module gic_sqrt import gic_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root,
  output logic [REM_W-1:0]  rem
);

  // Digit-by-digit integer square root, one result bit per cycle.
  logic             busy;
  logic [RAD_W-1:0] n;
  logic [RAD_W-1:0] r;
  logic [RAD_W-1:0] bitw;
  logic [RAD_W:0]   trial;
  logic             fits;

  assign trial = {1'b0, r} + {1'b0, bitw};
  assign fits  = {1'b0, n} >= trial;
  assign root  = r[ROOT_W-1:0];
  assign rem   = n[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      n    <= radicand;
      r    <= '0;
      bitw <= RAD_W'(1) << (RAD_W - 1);
    end else if (busy) begin
      if (fits) begin
        n <= n - trial[RAD_W-1:0];
        r <= (r >> 1) + bitw;
      end else begin
        r <= r >> 1;
      end
      bitw <= bitw >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitw[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/gic_back.sv
module gic_back import gic_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  output logic     q_pop,
  input  gic_job_t q_job,
  gic_out_if.source cond
);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_SUMSQ  = 3'd1;
  localparam logic [2:0] B_CHOOSE = 3'd2;
  localparam logic [2:0] B_MAG    = 3'd3;
  localparam logic [2:0] B_DIV    = 3'd4;
  localparam logic [2:0] B_ROOT   = 3'd5;
  localparam logic [2:0] B_OUT    = 3'd6;

  logic [2:0]        state;
  gic_job_t          job;
  logic signed [15:0] x_ext;
  logic signed [15:0] y_ext;
  logic [SQ_W-1:0]   xsq;
  logic [SQ_W-1:0]   ysq;
  logic [SUM_W-1:0]  s;
  logic              axis;
  logic [15:0]       ox;
  logic [15:0]       oy;
  logic [MAG_W-1:0]  mag;
  logic              out_valid;
  logic              load;
  logic              limit;

  logic              div_start;
  logic [SQ_W-1:0]   div_num;
  logic              div_done;
  logic [QUO_W-1:0]  div_quot;
  logic              sqrt_start;
  logic [RAD_W-1:0]  sqrt_rad;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic [REM_W-1:0]  sqrt_rem;
  logic [ROOT_W:0]   half_sum;
  logic [15:0]       qmag;
  logic              neg;
  logic [15:0]       sval;

  assign q_pop = (state == B_IDLE) && q_valid;
  assign limit = s > SUM_W'(MAG_LIMIT_SQ);
  assign load  = (state == B_OUT) && (!out_valid || cond.ready);

  // Sign-extended axes, so each square is formed at full width.
  assign x_ext = {{8{job.x[7]}}, job.x};
  assign y_ext = {{8{job.y[7]}}, job.y};

  assign div_start  = ((state == B_CHOOSE) && limit) ||
                      ((state == B_ROOT) && sqrt_done && !axis);
  assign div_num    = (state == B_CHOOSE) ? xsq : ysq;
  assign sqrt_start = ((state == B_CHOOSE) && !limit) ||
                      ((state == B_DIV) && div_done);
  assign sqrt_rad   = (state == B_CHOOSE) ? {s, 16'h0000} : div_quot;

  // The scaled axis is the largest q with 2q-1 <= root, which is (root+1)/2.
  assign half_sum = {1'b0, sqrt_root} + 1'b1;
  assign qmag     = half_sum[ROOT_W:1];
  assign neg      = axis ? job.y[7] : job.x[7];
  assign sval     = neg ? 16'h0000 - qmag : qmag;

  gic_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_sq (div_num),
    .den    (s),
    .done   (div_done),
    .quot   (div_quot)
  );

  gic_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root),
    .rem      (sqrt_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      axis  <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            state <= q_job.zero_stick ? B_OUT : B_SUMSQ;
          end
        end
        B_SUMSQ: begin
          state <= B_CHOOSE;
        end
        B_CHOOSE: begin
          axis  <= 1'b0;
          state <= limit ? B_DIV : B_MAG;
        end
        B_MAG: begin
          if (sqrt_done) begin
            state <= B_OUT;
          end
        end
        B_DIV: begin
          if (div_done) begin
            state <= B_ROOT;
          end
        end
        B_ROOT: begin
          if (sqrt_done) begin
            axis  <= 1'b1;
            state <= axis ? B_OUT : B_DIV;
          end
        end
        B_OUT: begin
          if (load) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        job <= q_job;
        ox  <= '0;
        oy  <= '0;
        mag <= '0;
      end
      B_SUMSQ: begin
        xsq <= SQ_W'(x_ext * x_ext);
        ysq <= SQ_W'(y_ext * y_ext);
        s   <= SUM_W'(x_ext * x_ext) + SUM_W'(y_ext * y_ext);
      end
      B_MAG: begin
        if (sqrt_done) begin
          mag <= MAG_W'(sqrt_root) + MAG_W'(sqrt_rem > REM_W'(sqrt_root));
          ox  <= {job.x, 8'h00};
          oy  <= {job.y, 8'h00};
        end
      end
      B_ROOT: begin
        if (sqrt_done) begin
          if (axis) begin
            oy  <= sval;
            mag <= MAG_W'(MAG_FULL);
          end else begin
            ox <= sval;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (cond.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cond.held_buttons     <= job.held;
      cond.pressed_buttons  <= job.pressed;
      cond.released_buttons <= job.released;
      cond.combo_hit        <= job.combo;
      cond.stick_x          <= ox;
      cond.stick_y          <= oy;
      cond.stick_mag        <= mag;
    end
  end

  assign cond.valid = out_valid;

  a_sqrt_done_state: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> (state == B_MAG || state == B_ROOT))
    else $error("square root finished outside a waiting state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == B_DIV))
    else $error("divide finished outside its waiting state");

  a_mag_limit: assert property (@(posedge clk) disable iff (rst)
    cond.valid |-> (cond.stick_mag <= MAG_W'(MAG_FULL)))
    else $error("stick magnitude above the limit");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != B_IDLE))
    else $error("frame taken from the queue but back end stayed idle");

endmodule

>>> hw/rtl/gamepad_input_conditioner_unit.sv
// Gamepad input conditioner. Each request on the pad channel is one controller
// frame; each produces exactly one result on the cond channel, in order. The
// front end handles a frame combinationally: it applies the button lock, forms
// held, pressed and released edges and the combo flag, applies the stick
// deadzone, and queues the frame. The back end then works out the stick length
// and limiting with one shared restoring divider and one shared digit-serial
// square root. A centered stick (or a disconnected pad) skips the arithmetic
// and goes straight to the output stage, a stick inside the 64.0 radius needs
// one 16-step square root, and a stick beyond it needs for each axis a
// 31-step divide followed by a 16-step square root. The back end handles one
// frame at a time, so that work sets the sustained rate; the queue lets the
// front end take up to QUEUE_DEPTH further frames meanwhile, and the output
// register lets the back end start the next frame while a result waits.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata
// and should only be changed while no frame is in flight.
module gamepad_input_conditioner_unit import gic_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  gic_in_if.sink      pad,
  gic_out_if.source   cond,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Configuration: alt_mode selects the wide deadzone; combo_mask is the button
  // set whose completion raises combo_hit.
  logic        alt_mode;
  logic [15:0] combo_mask;

  // Front end to queue, and queue to back end.
  logic     push_valid;
  logic     push_ready;
  gic_job_t push_job;
  logic     pop_valid;
  logic     pop;
  gic_job_t pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_mode   <= 1'b0;
      combo_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALT_MODE:   alt_mode   <= cfg_wdata[0];
        REG_COMBO_MASK: combo_mask <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The front end keeps the held and locked button masks, so edges follow the
  // order in which frames are accepted.
  gic_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pad        (pad),
    .alt_mode   (alt_mode),
    .combo_mask (combo_mask),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  gic_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_job    (pop_job)
  );

  // The back end owns the arithmetic and the output register.
  gic_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_pop   (pop),
    .q_job   (pop_job),
    .cond    (cond)
  );

endmodule
